@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

  localparam int unsigned PagesDef    = 4096;
  localparam int unsigned TopOrderDef = 10;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_REGION = 2'd2,
    FUNC_NOP    = 2'd3
  } bpa_func_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NOBLOCK = 2'd1,
    STATUS_IGNORED = 2'd2
  } bpa_status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_SEARCH,
    ST_A_POP,
    ST_A_SPLIT,
    ST_F_CHK,
    ST_F_MERGE,
    ST_F_BUD,
    ST_F_UNL,
    ST_R_LOOP,
    ST_R_FIT,
    ST_PUSH,
    ST_PUSH2,
    ST_FINISH
  } bpa_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  order;
    logic [11:0] page;
    logic [12:0] region_pages;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] block_page;
  } bpa_out_t;

endpackage

@@ rtl/bpa_ram.sv @@
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bpa_alu.sv @@
module bpa_alu #(
  parameter int unsigned LinkW  = 13,
  parameter int unsigned OrderW = 4
) (
  input  logic [LinkW-1:0]  a_i,
  input  logic [OrderW-1:0] k_i,
  input  logic [LinkW-1:0]  end_i,
  output logic [LinkW-1:0]  plus_o,
  output logic [LinkW-1:0]  flip_o,
  output logic [LinkW-1:0]  clr_o,
  output logic              fits_o
);

  logic [LinkW-1:0] size;

  // One power-of-two block size feeds every buddy computation.
  assign size   = LinkW'(1) << k_i;
  assign plus_o = a_i + size;
  assign flip_o = a_i ^ size;
  assign clr_o  = a_i & ~size;
  assign fits_o = (a_i < end_i) && (size <= (end_i - a_i)) &&
                  ((a_i & (size - LinkW'(1))) == '0);

endmodule

@@ rtl/buddy_page_allocator.sv @@
// Channel  | Signals                              | Direction
// config   | cfg_we_i, cfg_wdata_i                | in, write only, no wait
// request  | in_valid_i, in_ready_o, in_data_i    | in
// result   | out_valid_o, out_ready_i, out_data_o | out
//
// After reset a clearing pass zeroes the page metadata of every page; no
// request is taken meanwhile. A sequencer then walks the orders one per cycle
// and performs one read-modify-write step on the link and metadata memories
// per cycle. Allocate searches the orders and then splits, free merges with
// free buddies, and add region carves the range into aligned blocks. A result
// waits in the output register; a stalled result holds the sequencer in its
// final state.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned PAGES     = PagesDef,
  parameter int unsigned TOP_ORDER = TopOrderDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bpa_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bpa_out_t    out_data_o
);

  localparam int unsigned PW  = $clog2(PAGES);
  localparam int unsigned LW  = PW + 1;
  localparam int unsigned CW  = $clog2(TOP_ORDER + 2);
  localparam int unsigned HIW = $clog2(TOP_ORDER + 1);
  localparam int unsigned MW  = CW + 1;
  localparam logic [LW-1:0] NullLink = LW'(PAGES);
  localparam logic [CW-1:0] TopOrd   = CW'(TOP_ORDER);

  bpa_state_e state_q, state_d, ret_q, ret_d;
  logic [12:0]   pcount_q;
  logic [LW-1:0] head_q [TOP_ORDER+1];
  logic          head_we;
  logic [HIW-1:0] head_idx;
  logic [LW-1:0] head_wd;
  logic [PW-1:0] clr_q;

  // Working registers of the sequencer.
  logic [CW-1:0] ord_q, ord_d, cur_q, cur_d, k_q, k_d;
  logic [LW-1:0] p_q, p_d, x_q, x_d, b_q, b_d, end_q, end_d, lim_q, lim_d;
  logic [1:0]    st_q, st_d;
  logic [11:0]   blk_q, blk_d;
  logic          ovalid_q;
  bpa_out_t      odata_q;

  // Memory ports.
  logic          nl_we, pl_we, mt_we;
  logic [PW-1:0] nl_wa, pl_wa, mt_wa, nl_ra, pl_ra, mt_ra;
  logic [LW-1:0] nl_wd, pl_wd, nl_rd, pl_rd;
  logic [MW-1:0] mt_wd, mt_rd;

  // Shared arithmetic unit.
  logic [CW-1:0] alu_k;
  logic [LW-1:0] alu_plus, alu_flip, alu_clr;
  logic          alu_fits;

  logic [31:0] lim32, end32, page32;
  logic [LW-1:0] cur_head, push_head, nx_n, pr_n;

  bpa_ram #(.Width(LW), .Depth(PAGES)) u_next (
    .clk_i, .we_i(nl_we), .waddr_i(nl_wa), .wdata_i(nl_wd),
    .raddr_i(nl_ra), .rdata_o(nl_rd)
  );
  bpa_ram #(.Width(LW), .Depth(PAGES)) u_prev (
    .clk_i, .we_i(pl_we), .waddr_i(pl_wa), .wdata_i(pl_wd),
    .raddr_i(pl_ra), .rdata_o(pl_rd)
  );
  // Metadata entry: free flag above the block order.
  bpa_ram #(.Width(MW), .Depth(PAGES)) u_meta (
    .clk_i, .we_i(mt_we), .waddr_i(mt_wa), .wdata_i(mt_wd),
    .raddr_i(mt_ra), .rdata_o(mt_rd)
  );

  assign alu_k = (state_q == ST_A_SPLIT) ? (cur_q - CW'(1)) : cur_q;

  bpa_alu #(.LinkW(LW), .OrderW(CW)) u_alu (
    .a_i(p_q), .k_i(alu_k), .end_i(end_q),
    .plus_o(alu_plus), .flip_o(alu_flip), .clr_o(alu_clr), .fits_o(alu_fits)
  );

  // The effective pool limit is the smaller of the register and the pool.
  assign lim32  = (32'(pcount_q) < 32'(PAGES)) ? 32'(pcount_q) : 32'(PAGES);
  assign page32 = 32'(in_data_i.page);
  assign end32  = ((page32 + 32'(in_data_i.region_pages)) > lim32) ?
                  lim32 : (page32 + 32'(in_data_i.region_pages));

  assign cur_head  = head_q[cur_q[HIW-1:0]];
  assign push_head = head_q[k_q[HIW-1:0]];
  assign nx_n      = (nl_rd < NullLink) ? nl_rd : NullLink;
  assign pr_n      = (pl_rd < NullLink) ? pl_rd : NullLink;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ord_d   = ord_q;
    cur_d   = cur_q;
    k_d     = k_q;
    p_d     = p_q;
    x_d     = x_q;
    b_d     = b_q;
    end_d   = end_q;
    lim_d   = lim_q;
    st_d    = st_q;
    blk_d   = blk_q;
    head_we = 1'b0;
    head_idx = cur_q[HIW-1:0];
    head_wd = NullLink;
    nl_we = 1'b0; nl_wa = x_q[PW-1:0]; nl_wd = push_head; nl_ra = b_q[PW-1:0];
    pl_we = 1'b0; pl_wa = x_q[PW-1:0]; pl_wd = NullLink;  pl_ra = b_q[PW-1:0];
    mt_we = 1'b0; mt_wa = x_q[PW-1:0]; mt_wd = {1'b1, k_q};
    mt_ra = in_data_i.page[PW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mt_we = 1'b1;
        mt_wa = clr_q;
        mt_wd = '0;
        if (clr_q == PW'(PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          st_d  = STATUS_DONE;
          blk_d = '0;
          lim_d = LW'(lim32);
          p_d   = LW'(page32);
          ord_d = CW'(in_data_i.order);
          cur_d = CW'(in_data_i.order);
          end_d = LW'(end32);
          case (bpa_func_e'(in_data_i.func))
            FUNC_ALLOC: begin
              if (32'(in_data_i.order) > 32'(TOP_ORDER)) begin
                st_d    = STATUS_NOBLOCK;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_A_SEARCH;
              end
            end
            FUNC_FREE: begin
              if (32'(in_data_i.order) > 32'(TOP_ORDER) || page32 >= lim32) begin
                st_d    = STATUS_IGNORED;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_F_CHK;
              end
            end
            FUNC_REGION: begin
              if (page32 >= lim32) begin
                st_d    = STATUS_IGNORED;
                state_d = ST_FINISH;
              end else begin
                state_d = ST_R_LOOP;
              end
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_A_SEARCH: begin
        if (cur_q > TopOrd) begin
          st_d    = STATUS_NOBLOCK;
          state_d = ST_FINISH;
        end else if (cur_head == NullLink) begin
          cur_d = cur_q + CW'(1);
        end else begin
          // Pop the head: mark it taken and fetch its successor.
          p_d     = cur_head;
          mt_we   = 1'b1;
          mt_wa   = cur_head[PW-1:0];
          mt_wd   = {1'b0, ord_q};
          nl_ra   = cur_head[PW-1:0];
          state_d = ST_A_POP;
        end
      end
      ST_A_POP: begin
        if (nx_n != NullLink) begin
          pl_we = 1'b1;
          pl_wa = nx_n[PW-1:0];
          pl_wd = NullLink;
        end
        head_we = 1'b1;
        head_wd = nx_n;
        state_d = ST_A_SPLIT;
      end
      ST_A_SPLIT: begin
        if (cur_q > ord_q) begin
          cur_d = cur_q - CW'(1);
          if (alu_plus < NullLink) begin
            k_d     = cur_q - CW'(1);
            x_d     = alu_plus;
            ret_d   = ST_A_SPLIT;
            state_d = ST_PUSH;
          end
        end else begin
          blk_d   = 12'(p_q);
          state_d = ST_FINISH;
        end
      end
      ST_F_CHK: begin
        if (mt_rd[MW-1]) begin
          st_d    = STATUS_IGNORED;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_F_MERGE;
        end
      end
      ST_F_MERGE: begin
        if (cur_q >= TopOrd || alu_flip >= lim_q) begin
          k_d     = cur_q;
          x_d     = p_q;
          ret_d   = ST_FINISH;
          state_d = ST_PUSH;
        end else begin
          b_d     = alu_flip;
          mt_ra   = alu_flip[PW-1:0];
          state_d = ST_F_BUD;
        end
      end
      ST_F_BUD: begin
        if (!mt_rd[MW-1] || mt_rd[CW-1:0] != cur_q) begin
          k_d     = cur_q;
          x_d     = p_q;
          ret_d   = ST_FINISH;
          state_d = ST_PUSH;
        end else begin
          state_d = ST_F_UNL;
        end
      end
      ST_F_UNL: begin
        // Unlink the buddy from its list and merge.
        if (pr_n != NullLink) begin
          nl_we = 1'b1;
          nl_wa = pr_n[PW-1:0];
          nl_wd = nx_n;
        end else begin
          head_we = 1'b1;
          head_wd = nx_n;
        end
        if (nx_n != NullLink) begin
          pl_we = 1'b1;
          pl_wa = nx_n[PW-1:0];
          pl_wd = pr_n;
        end
        mt_we   = 1'b1;
        mt_wa   = b_q[PW-1:0];
        mt_wd   = {1'b0, cur_q};
        p_d     = alu_clr;
        cur_d   = cur_q + CW'(1);
        state_d = ST_F_MERGE;
      end
      ST_R_LOOP: begin
        if (p_q >= end_q) begin
          state_d = ST_FINISH;
        end else begin
          cur_d   = TopOrd;
          state_d = ST_R_FIT;
        end
      end
      ST_R_FIT: begin
        if (alu_fits) begin
          k_d     = cur_q;
          x_d     = p_q;
          p_d     = alu_plus;
          ret_d   = ST_R_LOOP;
          state_d = ST_PUSH;
        end else begin
          cur_d = cur_q - CW'(1);
        end
      end
      ST_PUSH: begin
        nl_we   = 1'b1;
        pl_we   = 1'b1;
        mt_we   = 1'b1;
        state_d = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (push_head != NullLink) begin
          pl_we = 1'b1;
          pl_wa = push_head[PW-1:0];
          pl_wd = x_q;
        end
        head_we  = 1'b1;
        head_idx = k_q[HIW-1:0];
        head_wd  = x_q;
        state_d  = ret_q;
      end
      ST_FINISH: begin
        if (!ovalid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ret_q    <= ST_FINISH;
      clr_q    <= '0;
      pcount_q <= 13'(PAGES);
      ovalid_q <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
        head_q[i] <= NullLink;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + PW'(1);
      end
      if (cfg_we_i) begin
        pcount_q <= cfg_wdata_i;
      end
      if (head_we) begin
        head_q[head_idx] <= head_wd;
      end
      if (state_q == ST_FINISH && (!ovalid_q || out_ready_i)) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q <= ord_d;
    cur_q <= cur_d;
    k_q   <= k_d;
    p_q   <= p_d;
    x_q   <= x_d;
    b_q   <= b_d;
    end_q <= end_d;
    lim_q <= lim_d;
    st_q  <= st_d;
    blk_q <= blk_d;
    if (state_q == ST_FINISH && (!ovalid_q || out_ready_i)) begin
      odata_q.status     <= st_q;
      odata_q.block_page <= blk_q;
    end
  end

endmodule

@@ bench/tb.sv @@
`default_nettype none

module tb;
  import bpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPAGES = PagesDef;
  localparam int unsigned TOPORD = TopOrderDef;
  localparam int unsigned NIL    = NPAGES;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  bpa_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  bpa_out_t    out_data_o;

  buddy_page_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the allocator: page count, list heads, links and the
  // per-page free flag and order.
  int unsigned page_limit_reg = NPAGES;
  int unsigned free_head[TOPORD+1];
  int unsigned next_pg[NPAGES];
  int unsigned prev_pg[NPAGES];
  bit          pg_free[NPAGES];
  int unsigned pg_order[NPAGES];

  // Results still owed by the block, oldest first.
  bpa_out_t    owed_results[$];
  // Blocks handed out by allocate transactions, kept so that frees are
  // mostly well formed.
  int unsigned held_page[$];
  int unsigned held_order[$];

  int unsigned mismatch_cnt = 0;
  bit          steady = 1'b0;   // when set, neither side idles
  int unsigned rx_hold = 0;     // receiver hold-off, in cycles

  function automatic int unsigned active_limit();
    return (page_limit_reg < NPAGES) ? page_limit_reg : NPAGES;
  endfunction

  function automatic void list_push(int unsigned o, int unsigned p);
    int unsigned h;
    h = free_head[o];
    prev_pg[p] = NIL;
    pg_free[p] = 1'b1;
    pg_order[p] = o;
    if (h < NPAGES) prev_pg[h] = p;
    next_pg[p] = (h < NPAGES) ? h : NIL;
    free_head[o] = p;
  endfunction

  function automatic int unsigned list_pop(int unsigned o);
    int unsigned h, n;
    h = free_head[o];
    if (h >= NPAGES) return NIL;
    pg_free[h] = 1'b0;
    n = next_pg[h];
    if (n < NPAGES) prev_pg[n] = NIL;
    free_head[o] = (n < NPAGES) ? n : NIL;
    return h;
  endfunction

  function automatic void list_unlink(int unsigned o, int unsigned p);
    int unsigned pr, nx;
    pr = prev_pg[p];
    nx = next_pg[p];
    if (nx >= NPAGES) nx = NIL;
    if (pr < NPAGES) next_pg[pr] = nx;
    else free_head[o] = nx;
    if (nx < NPAGES) prev_pg[nx] = (pr < NPAGES) ? pr : NIL;
  endfunction

  // Applies one request to the shadow state and returns the result that the
  // block must produce for it.
  function automatic bpa_out_t apply_request(bpa_in_t req);
    bpa_out_t    res;
    int unsigned lim, cur, base, q, o, p, sz, bud, stop;
    bit          placed;
    res = '0;
    res.status = STATUS_DONE;
    lim = active_limit();
    o = req.order;
    p = req.page;
    case (req.func)
      FUNC_ALLOC: begin
        cur = o;
        while (cur <= TOPORD && free_head[cur] >= NPAGES) cur++;
        if (cur > TOPORD) begin
          res.status = STATUS_NOBLOCK;
        end else begin
          base = list_pop(cur);
          while (cur > o) begin
            cur--;
            q = base + (1 << cur);
            if (q < NPAGES) list_push(cur, q);
          end
          pg_order[base] = o;
          res.block_page = base[11:0];
        end
      end
      FUNC_FREE: begin
        if (o > TOPORD || p >= lim || pg_free[p]) begin
          res.status = STATUS_IGNORED;
        end else begin
          // Merge upward while the buddy is a free block of the same order.
          while (o < TOPORD) begin
            sz = 1 << o;
            bud = p ^ sz;
            if (bud >= lim || !pg_free[bud] || pg_order[bud] != o) break;
            list_unlink(o, bud);
            pg_free[bud] = 1'b0;
            p = p & ~sz;
            o++;
          end
          list_push(o, p);
        end
      end
      FUNC_REGION: begin
        if (p >= lim) begin
          res.status = STATUS_IGNORED;
        end else begin
          stop = p + req.region_pages;
          if (stop > lim) stop = lim;
          // Carve into the largest aligned block that still fits.
          while (p < stop) begin
            placed = 1'b0;
            for (int k = TOPORD; k >= 0 && !placed; k--) begin
              sz = 1 << k;
              if (sz <= stop - p && (p & (sz - 1)) == 0) begin
                list_push(k, p);
                p += sz;
                placed = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offers one request and returns once the block has taken it. Valid stays
  // high afterwards, so back-to-back calls keep the channel busy unless steady is clear and a random idle gap comes.
  task automatic send_request(bpa_in_t req);
    bpa_out_t res;
    if (!steady && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 50) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    res = apply_request(req);
    owed_results.push_back(res);
    if (req.func == FUNC_ALLOC && res.status == STATUS_DONE) begin
      held_page.push_back(res.block_page);
      held_order.push_back(req.order);
    end
  endtask

  task automatic send_fields(bpa_func_e f, int unsigned o, int unsigned p,
                             int unsigned n);
    bpa_in_t req;
    req.func = f;
    req.order = o[3:0];
    req.page = p[11:0];
    req.region_pages = n[12:0];
    send_request(req);
  endtask

  // Lowers valid and waits for every owed result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_page_count(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[12:0];
    @(posedge clk_i);
    page_limit_reg = v & 13'h1fff;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stalls plus an optional long hold-off, and a check
  // of each result transaction against the oldest owed result.
  always @(posedge clk_i) begin
    bpa_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with nothing outstanding: status %0d page %0d",
                   $realtime, out_data_o.status, out_data_o.block_page);
      end else begin
        want = owed_results.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.block_page !== want.block_page) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: expected status %0d page %0d, got status %0d page %0d",
                     $realtime, want.status, want.block_page,
                     out_data_o.status, out_data_o.block_page);
        end
      end
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 13);
    end
  end

  // Directed corner cases: empty pool, orders above the top, out-of-range
  // and double frees, unaligned frees, empty regions and the unused func.
  task automatic test_corners();
    send_fields(FUNC_ALLOC, 0, 0, 0);          // nothing free yet
    send_fields(FUNC_FREE, 0, 4095, 0);        // free of a page not free
    send_fields(FUNC_ALLOC, 15, 0, 0);         // above the top order
    send_fields(FUNC_ALLOC, 11, 0, 0);
    send_fields(FUNC_REGION, 0, 0, 0);         // empty region
    send_fields(FUNC_REGION, 0, 0, 4096);      // whole pool
    send_fields(FUNC_ALLOC, 10, 0, 0);
    send_fields(FUNC_ALLOC, 0, 0, 0);
    send_fields(FUNC_ALLOC, 3, 0, 0);
    send_fields(FUNC_FREE, 12, 2048, 0);       // free above the top order
    send_fields(FUNC_FREE, 0, 1024, 0);        // page already free: ignored
    send_fields(FUNC_FREE, 0, 1024, 0);        // already free again
    send_fields(FUNC_FREE, 10, 0, 0);          // top order, page already free
    send_fields(FUNC_ALLOC, 2, 0, 0);
    send_fields(FUNC_FREE, 2, 3074, 0);        // unaligned start
    send_fields(FUNC_NOP, 15, 4095, 8191);
    send_fields(FUNC_ALLOC, 10, 0, 0);
    send_fields(FUNC_ALLOC, 10, 0, 0);
    send_fields(FUNC_ALLOC, 10, 0, 0);         // likely exhausted
    write_page_count(100);
    send_fields(FUNC_FREE, 0, 100, 0);         // out of range
    send_fields(FUNC_REGION, 0, 100, 10);      // start out of range
    send_fields(FUNC_REGION, 0, 37, 4096);     // end clipped to the limit
    send_fields(FUNC_ALLOC, 0, 0, 0);
    drain();
  endtask

  task automatic random_request(int unsigned region_pct);
    int unsigned pick, idx, r;
    r = $urandom_range(99);
    if (r < region_pct) begin
      send_fields(FUNC_REGION, $urandom_range(15), $urandom_range(4095),
                  ($urandom_range(3) == 0) ? $urandom_range(8191)
                                           : $urandom_range(64));
    end else if (r < 50) begin
      pick = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4);
      send_fields(FUNC_ALLOC, pick, $urandom_range(4095), $urandom_range(8191));
    end else if (r < 88 && held_page.size() != 0) begin
      idx = $urandom_range(held_page.size() - 1);
      send_fields(FUNC_FREE, held_order[idx], held_page[idx], $urandom_range(8191));
      held_page.delete(idx);
      held_order.delete(idx);
    end else if (r < 95) begin
      // Noise: random frees, mostly ignored or odd.
      send_fields(FUNC_FREE, $urandom_range(15), $urandom_range(4095),
                  $urandom_range(8191));
    end else begin
      send_fields(FUNC_NOP, $urandom_range(15), $urandom_range(4095),
                  $urandom_range(8191));
    end
  endtask

  // One random phase per pool size, each starting from a freshly added region.
  task automatic test_random_phases();
    int unsigned sizes[5] = '{4096, 1, 8191, 1000, 4096};
    foreach (sizes[s]) begin
      write_page_count(sizes[s]);
      held_page.delete();
      held_order.delete();
      send_fields(FUNC_REGION, 0, 0, 4096);
      steady = (s == 2);
      for (int i = 0; i < 96; i++) random_request(5);
      steady = 1'b0;
    end
    drain();
  endtask

  // The receiver stops for a long stretch while requests keep coming, so
  // the block fills and stalls its request side.
  task automatic test_backpressure();
    rx_hold = 300;
    for (int i = 0; i < 20; i++) random_request(5);
    drain();
  endtask

  // Overlapping regions push pages that are already free.
  task automatic test_overlap();
    send_fields(FUNC_REGION, 0, 0, 64);
    send_fields(FUNC_REGION, 0, 32, 64);
    for (int i = 0; i < 20; i++) random_request(10);
    drain();
  endtask

  initial begin
    for (int k = 0; k <= TOPORD; k++) free_head[k] = NIL;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_corners();
    test_random_phases();
    test_backpressure();
    test_overlap();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
